>>> rtl/frt_pkg.sv
// Shared types, constants and geometry tables for the fat tree route generator.
package frt_pkg;

  localparam int MAX_HALF_RADIX = 32;
  localparam int RADIX_IDX_W    = 5;
  localparam int NODE_W         = 17;
  localparam int HOST_W         = 16;
  localparam int CHOICE_W       = 5;
  localparam int RADIX_W        = 6;
  localparam int EDGE_W         = 11;
  localparam int POD_W          = 6;
  localparam int MAX_HOPS       = 7;
  localparam int HOP_IDX_W      = 3;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_W    = 2;
  localparam int QUEUE_CNT_W    = 3;
  localparam int M1_W           = 23;
  localparam int M2_W           = 27;
  localparam int M1_SHIFT       = 22;
  localparam int M2_SHIFT       = 26;

  typedef enum logic [1:0] {
    LVL_HOST = 2'd0,
    LVL_EDGE = 2'd1,
    LVL_AGG  = 2'd2,
    LVL_CORE = 2'd3
  } level_t;

  typedef struct packed {
    logic [NODE_W-1:0] id;
    level_t            level;
  } hop_t;

  typedef struct packed {
    hop_t [MAX_HOPS-1:0]  hops;
    logic [HOP_IDX_W-1:0] last_idx;
    logic                 blocked;
  } route_t;

  typedef struct packed {
    logic [RADIX_W-1:0] h;
    logic [NODE_W-1:0]  hosts;
    logic [NODE_W-1:0]  agg_base;
    logic [NODE_W-1:0]  core_base;
    logic [M1_W-1:0]    m1;
    logic [M2_W-1:0]    m2;
  } geom_t;

  // Reciprocals ceil(2^22 / h): exact floor(x / h) for any 16-bit x.
  localparam logic [M1_W-1:0] RECIP_H [MAX_HALF_RADIX] = '{
    23'((4194304 + 1 - 1) / 1),   23'((4194304 + 2 - 1) / 2),
    23'((4194304 + 3 - 1) / 3),   23'((4194304 + 4 - 1) / 4),
    23'((4194304 + 5 - 1) / 5),   23'((4194304 + 6 - 1) / 6),
    23'((4194304 + 7 - 1) / 7),   23'((4194304 + 8 - 1) / 8),
    23'((4194304 + 9 - 1) / 9),   23'((4194304 + 10 - 1) / 10),
    23'((4194304 + 11 - 1) / 11), 23'((4194304 + 12 - 1) / 12),
    23'((4194304 + 13 - 1) / 13), 23'((4194304 + 14 - 1) / 14),
    23'((4194304 + 15 - 1) / 15), 23'((4194304 + 16 - 1) / 16),
    23'((4194304 + 17 - 1) / 17), 23'((4194304 + 18 - 1) / 18),
    23'((4194304 + 19 - 1) / 19), 23'((4194304 + 20 - 1) / 20),
    23'((4194304 + 21 - 1) / 21), 23'((4194304 + 22 - 1) / 22),
    23'((4194304 + 23 - 1) / 23), 23'((4194304 + 24 - 1) / 24),
    23'((4194304 + 25 - 1) / 25), 23'((4194304 + 26 - 1) / 26),
    23'((4194304 + 27 - 1) / 27), 23'((4194304 + 28 - 1) / 28),
    23'((4194304 + 29 - 1) / 29), 23'((4194304 + 30 - 1) / 30),
    23'((4194304 + 31 - 1) / 31), 23'((4194304 + 32 - 1) / 32)
  };

  // Reciprocals ceil(2^26 / h^2): exact floor(x / h^2) for any 16-bit x.
  localparam logic [M2_W-1:0] RECIP_H2 [MAX_HALF_RADIX] = '{
    27'((67108864 + 1*1 - 1) / (1*1)),     27'((67108864 + 2*2 - 1) / (2*2)),
    27'((67108864 + 3*3 - 1) / (3*3)),     27'((67108864 + 4*4 - 1) / (4*4)),
    27'((67108864 + 5*5 - 1) / (5*5)),     27'((67108864 + 6*6 - 1) / (6*6)),
    27'((67108864 + 7*7 - 1) / (7*7)),     27'((67108864 + 8*8 - 1) / (8*8)),
    27'((67108864 + 9*9 - 1) / (9*9)),     27'((67108864 + 10*10 - 1) / (10*10)),
    27'((67108864 + 11*11 - 1) / (11*11)), 27'((67108864 + 12*12 - 1) / (12*12)),
    27'((67108864 + 13*13 - 1) / (13*13)), 27'((67108864 + 14*14 - 1) / (14*14)),
    27'((67108864 + 15*15 - 1) / (15*15)), 27'((67108864 + 16*16 - 1) / (16*16)),
    27'((67108864 + 17*17 - 1) / (17*17)), 27'((67108864 + 18*18 - 1) / (18*18)),
    27'((67108864 + 19*19 - 1) / (19*19)), 27'((67108864 + 20*20 - 1) / (20*20)),
    27'((67108864 + 21*21 - 1) / (21*21)), 27'((67108864 + 22*22 - 1) / (22*22)),
    27'((67108864 + 23*23 - 1) / (23*23)), 27'((67108864 + 24*24 - 1) / (24*24)),
    27'((67108864 + 25*25 - 1) / (25*25)), 27'((67108864 + 26*26 - 1) / (26*26)),
    27'((67108864 + 27*27 - 1) / (27*27)), 27'((67108864 + 28*28 - 1) / (28*28)),
    27'((67108864 + 29*29 - 1) / (29*29)), 27'((67108864 + 30*30 - 1) / (30*30)),
    27'((67108864 + 31*31 - 1) / (31*31)), 27'((67108864 + 32*32 - 1) / (32*32))
  };

  localparam logic [10:0] SQUARE_H [MAX_HALF_RADIX] = '{
    11'(1*1),   11'(2*2),   11'(3*3),   11'(4*4),   11'(5*5),   11'(6*6),
    11'(7*7),   11'(8*8),   11'(9*9),   11'(10*10), 11'(11*11), 11'(12*12),
    11'(13*13), 11'(14*14), 11'(15*15), 11'(16*16), 11'(17*17), 11'(18*18),
    11'(19*19), 11'(20*20), 11'(21*21), 11'(22*22), 11'(23*23), 11'(24*24),
    11'(25*25), 11'(26*26), 11'(27*27), 11'(28*28), 11'(29*29), 11'(30*30),
    11'(31*31), 11'(32*32)
  };

  localparam logic [15:0] CUBE_H [MAX_HALF_RADIX] = '{
    16'(1*1*1),    16'(2*2*2),    16'(3*3*3),    16'(4*4*4),
    16'(5*5*5),    16'(6*6*6),    16'(7*7*7),    16'(8*8*8),
    16'(9*9*9),    16'(10*10*10), 16'(11*11*11), 16'(12*12*12),
    16'(13*13*13), 16'(14*14*14), 16'(15*15*15), 16'(16*16*16),
    16'(17*17*17), 16'(18*18*18), 16'(19*19*19), 16'(20*20*20),
    16'(21*21*21), 16'(22*22*22), 16'(23*23*23), 16'(24*24*24),
    16'(25*25*25), 16'(26*26*26), 16'(27*27*27), 16'(28*28*28),
    16'(29*29*29), 16'(30*30*30), 16'(31*31*31), 16'(32*32*32)
  };

  // Clamps a written radix value and derives the tree geometry from it.
  function automatic geom_t geom_from(input logic [RADIX_W-1:0] value);
    logic [RADIX_W-1:0]     hc;
    logic [RADIX_IDX_W-1:0] idx;
    logic [NODE_W-1:0]      sq2;
    geom_t                  g;
    hc = value;
    if (value == '0) begin
      hc = RADIX_W'(1);
    end else if (value > RADIX_W'(MAX_HALF_RADIX)) begin
      hc = RADIX_W'(MAX_HALF_RADIX);
    end
    idx         = RADIX_IDX_W'(hc - RADIX_W'(1));
    sq2         = {5'b0, SQUARE_H[idx], 1'b0};
    g.h         = hc;
    g.hosts     = {CUBE_H[idx], 1'b0};
    g.agg_base  = g.hosts + sq2;
    g.core_base = g.agg_base + sq2;
    g.m1        = RECIP_H[idx];
    g.m2        = RECIP_H2[idx];
    return g;
  endfunction

endpackage

>>> rtl/frt_front.sv
// Front end: holds the radix register, accepts requests and builds routes.
module frt_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wen,
  input  logic [frt_pkg::RADIX_W-1:0]     cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [frt_pkg::HOST_W-1:0]      source_host,
  input  logic [frt_pkg::HOST_W-1:0]      dest_host,
  input  logic [frt_pkg::CHOICE_W-1:0]    agg_choice,
  input  logic [frt_pkg::CHOICE_W-1:0]    core_choice,
  input  logic [frt_pkg::QUEUE_CNT_W-1:0] queue_count,
  output logic                            push,
  output frt_pkg::route_t                 push_data
);
  import frt_pkg::*;

  geom_t geom;

  logic                s1_valid;
  logic [HOST_W-1:0]   s1_src;
  logic [HOST_W-1:0]   s1_dst;
  logic [CHOICE_W-1:0] s1_ac;
  logic [CHOICE_W-1:0] s1_cc;
  logic                s1_oob;
  logic                s1_same;

  logic                s2_valid;
  logic [HOST_W-1:0]   s2_src;
  logic [HOST_W-1:0]   s2_dst;
  logic [CHOICE_W-1:0] s2_ac;
  logic [CHOICE_W-1:0] s2_cc;
  logic                s2_oob;
  logic                s2_same;
  logic [EDGE_W-1:0]   s2_se;
  logic [EDGE_W-1:0]   s2_de;
  logic [POD_W-1:0]    s2_sp;
  logic [POD_W-1:0]    s2_dp;

  logic [QUEUE_CNT_W:0]           occupancy;
  logic                           accept;
  logic [CHOICE_W-1:0]            ac_sat;
  logic [CHOICE_W-1:0]            cc_sat;
  logic [HOST_W+M1_W-1:0]         src_q1;
  logic [HOST_W+M1_W-1:0]         dst_q1;
  logic [HOST_W+M2_W-1:0]         src_q2;
  logic [HOST_W+M2_W-1:0]         dst_q2;
  logic [RADIX_W+POD_W-1:0]       h_sp;
  logic [RADIX_W+POD_W-1:0]       h_dp;
  logic [RADIX_W+CHOICE_W-1:0]    h_ac;
  logic [NODE_W-1:0]              edge_s;
  logic [NODE_W-1:0]              edge_d;
  logic [NODE_W-1:0]              agg_s;
  logic [NODE_W-1:0]              agg_d;
  logic [NODE_W-1:0]              core_n;
  route_t                         route;

  always_ff @(posedge clk) begin
    if (rst) begin
      geom <= geom_from(RADIX_W'(2));
    end else if (cfg_wen) begin
      geom <= geom_from(cfg_wdata);
    end
  end

  // Every request in flight holds a queue slot, so the pipeline never stalls.
  assign occupancy = {1'b0, queue_count} + (QUEUE_CNT_W+1)'(s1_valid)
                     + (QUEUE_CNT_W+1)'(s2_valid);
  assign in_ready  = occupancy < (QUEUE_CNT_W+1)'(QUEUE_DEPTH);
  assign accept    = in_valid && in_ready;

  always_comb begin
    ac_sat = agg_choice;
    cc_sat = core_choice;
    if ({1'b0, agg_choice} >= geom.h) begin
      ac_sat = CHOICE_W'(geom.h - RADIX_W'(1));
    end
    if ({1'b0, core_choice} >= geom.h) begin
      cc_sat = CHOICE_W'(geom.h - RADIX_W'(1));
    end
  end

  assign src_q1 = (HOST_W+M1_W)'(s1_src) * (HOST_W+M1_W)'(geom.m1);
  assign dst_q1 = (HOST_W+M1_W)'(s1_dst) * (HOST_W+M1_W)'(geom.m1);
  assign src_q2 = (HOST_W+M2_W)'(s1_src) * (HOST_W+M2_W)'(geom.m2);
  assign dst_q2 = (HOST_W+M2_W)'(s1_dst) * (HOST_W+M2_W)'(geom.m2);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
    end
    if (accept) begin
      s1_src  <= source_host;
      s1_dst  <= dest_host;
      s1_ac   <= ac_sat;
      s1_cc   <= cc_sat;
      s1_oob  <= ({1'b0, source_host} >= geom.hosts) || ({1'b0, dest_host} >= geom.hosts);
      s1_same <= source_host == dest_host;
    end
    s2_src  <= s1_src;
    s2_dst  <= s1_dst;
    s2_ac   <= s1_ac;
    s2_cc   <= s1_cc;
    s2_oob  <= s1_oob;
    s2_same <= s1_same;
    s2_se   <= src_q1[M1_SHIFT +: EDGE_W];
    s2_de   <= dst_q1[M1_SHIFT +: EDGE_W];
    s2_sp   <= src_q2[M2_SHIFT +: POD_W];
    s2_dp   <= dst_q2[M2_SHIFT +: POD_W];
  end

  assign h_sp   = (RADIX_W+POD_W)'(geom.h) * (RADIX_W+POD_W)'(s2_sp);
  assign h_dp   = (RADIX_W+POD_W)'(geom.h) * (RADIX_W+POD_W)'(s2_dp);
  assign h_ac   = (RADIX_W+CHOICE_W)'(geom.h) * (RADIX_W+CHOICE_W)'(s2_ac);
  assign edge_s = geom.hosts + NODE_W'(s2_se);
  assign edge_d = geom.hosts + NODE_W'(s2_de);
  assign agg_s  = geom.agg_base + NODE_W'(s2_ac) + NODE_W'(h_sp);
  assign agg_d  = geom.agg_base + NODE_W'(s2_ac) + NODE_W'(h_dp);
  assign core_n = geom.core_base + NODE_W'(s2_cc) + NODE_W'(h_ac);

  always_comb begin
    route            = '0;
    route.hops[0].id = NODE_W'(s2_src);
    if (s2_oob) begin
      route.hops[0].id = '0;
      route.blocked    = 1'b1;
    end else if (s2_same) begin
      route.last_idx = HOP_IDX_W'(0);
    end else if (s2_se == s2_de) begin
      route.hops[1] = '{id: edge_s, level: LVL_EDGE};
      route.hops[2] = '{id: NODE_W'(s2_dst), level: LVL_HOST};
      route.last_idx = HOP_IDX_W'(2);
    end else if (s2_sp == s2_dp) begin
      route.hops[1] = '{id: edge_s, level: LVL_EDGE};
      route.hops[2] = '{id: agg_s, level: LVL_AGG};
      route.hops[3] = '{id: edge_d, level: LVL_EDGE};
      route.hops[4] = '{id: NODE_W'(s2_dst), level: LVL_HOST};
      route.last_idx = HOP_IDX_W'(4);
    end else begin
      route.hops[1] = '{id: edge_s, level: LVL_EDGE};
      route.hops[2] = '{id: agg_s, level: LVL_AGG};
      route.hops[3] = '{id: core_n, level: LVL_CORE};
      route.hops[4] = '{id: agg_d, level: LVL_AGG};
      route.hops[5] = '{id: edge_d, level: LVL_EDGE};
      route.hops[6] = '{id: NODE_W'(s2_dst), level: LVL_HOST};
      route.last_idx = HOP_IDX_W'(6);
    end
  end

  assign push      = s2_valid;
  assign push_data = route;

endmodule

>>> rtl/frt_queue.sv
// Short route queue between the front end and the hop emitter.
module frt_queue (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  frt_pkg::route_t                 push_data,
  input  logic                            pop,
  output frt_pkg::route_t                 head,
  output logic                            empty,
  output logic [frt_pkg::QUEUE_CNT_W-1:0] count
);
  import frt_pkg::*;

  route_t                 slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QUEUE_CNT_W'(1);
      end
    end
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  assign head  = slots[rd_ptr];
  assign empty = count == '0;

endmodule

>>> rtl/frt_back.sv
// Back end: walks the route at the queue head and emits one hop per transaction.
module frt_back (
  input  logic                         clk,
  input  logic                         rst,
  input  frt_pkg::route_t              head,
  input  logic                         empty,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [frt_pkg::NODE_W-1:0]   node_id,
  output logic [1:0]                   node_level,
  output logic                         last_hop,
  output logic                         blocked
);
  import frt_pkg::*;

  logic [HOP_IDX_W-1:0] step;
  logic                 load;
  logic                 take;

  assign load = !out_valid || out_ready;
  assign take = load && !empty;
  assign pop  = take && (step == head.last_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= '0;
    end else if (load) begin
      out_valid <= !empty;
      if (take) begin
        step <= pop ? '0 : step + HOP_IDX_W'(1);
      end
    end
    if (take) begin
      node_id    <= head.hops[step].id;
      node_level <= head.hops[step].level;
      last_hop   <= step == head.last_idx;
      blocked    <= head.blocked;
    end
  end

endmodule

>>> rtl/fat_tree_route_generator.sv
// Top level of the fat tree up/down route generator.
// Each request transaction yields the path from source host to destination host as a
// series of output transactions, one node each, the final one flagged by last_hop:
// 1 node when the hosts are equal or either is out of range (then blocked is set),
// 3 on a shared edge switch, 5 within a pod and 7 across pods. The hop emitter
// delivers one node per cycle while out_ready is high, so the rate of a request
// stream is set by the path length; the output register is the limit. A new
// request passes through the registered classification stages (reciprocal multiply
// by the radix) and a four-entry route queue, which lets requests be taken while
// earlier paths are still being sent. half_radix is clamped to 1..32 when written
// and must only change while no request is in flight.
module fat_tree_route_generator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [frt_pkg::RADIX_W-1:0]   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [frt_pkg::HOST_W-1:0]    source_host,
  input  logic [frt_pkg::HOST_W-1:0]    dest_host,
  input  logic [frt_pkg::CHOICE_W-1:0]  agg_choice,
  input  logic [frt_pkg::CHOICE_W-1:0]  core_choice,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [frt_pkg::NODE_W-1:0]    node_id,
  output logic [1:0]                    node_level,
  output logic                          last_hop,
  output logic                          blocked
);
  import frt_pkg::*;

  logic                   push;
  route_t                 push_data;
  logic                   pop;
  route_t                 head;
  logic                   empty;
  logic [QUEUE_CNT_W-1:0] count;

  frt_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .source_host (source_host),
    .dest_host   (dest_host),
    .agg_choice  (agg_choice),
    .core_choice (core_choice),
    .queue_count (count),
    .push        (push),
    .push_data   (push_data)
  );

  frt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .count     (count)
  );

  frt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .node_id    (node_id),
    .node_level (node_level),
    .last_hop   (last_hop),
    .blocked    (blocked)
  );

endmodule

>>> bench/frt_route_checker.sv
// Route checker: predicts each request's hop sequence and compares it with the node stream.
`timescale 1ns / 100ps

module frt_route_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wen,
  input  logic [frt_pkg::RADIX_W-1:0]  cfg_wdata,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [frt_pkg::HOST_W-1:0]   source_host,
  input  logic [frt_pkg::HOST_W-1:0]   dest_host,
  input  logic [frt_pkg::CHOICE_W-1:0] agg_choice,
  input  logic [frt_pkg::CHOICE_W-1:0] core_choice,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [frt_pkg::NODE_W-1:0]   node_id,
  input  logic [1:0]                   node_level,
  input  logic                         last_hop,
  input  logic                         blocked,
  output int                           errors,
  output int                           outstanding
);
  import frt_pkg::*;

  typedef struct packed {
    logic [NODE_W-1:0] id;
    level_t            level;
    logic              last;
    logic              blk;
  } hop_rec_t;

  logic [RADIX_W-1:0] radix_reg;
  hop_rec_t           path_q[$];
  hop_rec_t           want;

  initial begin
    errors      = 0;
    outstanding = 0;
    radix_reg   = RADIX_W'(2);
  end

  task automatic report_mismatch(input string what);
    $display("checker: %0t ns: %s", $time, what);
    errors++;
  endtask

  function automatic hop_rec_t make_hop(input int unsigned id, input level_t lvl);
    hop_rec_t r;
    r.id    = NODE_W'(id);
    r.level = lvl;
    r.last  = 1'b0;
    r.blk   = 1'b0;
    return r;
  endfunction

  // Queues the full path that one request should produce under the current radix.
  function automatic void plan_route(input logic [HOST_W-1:0] src, input logic [HOST_W-1:0] dst,
                                     input logic [CHOICE_W-1:0] ac_in,
                                     input logic [CHOICE_W-1:0] cc_in);
    int unsigned h, ac, cc, hosts, edge_base, agg_base, core_base, se, de, sp, dp;
    hop_rec_t    hops[$];
    hop_rec_t    r;
    h = radix_reg;
    if (h == 0) h = 1;
    if (h > MAX_HALF_RADIX) h = MAX_HALF_RADIX;
    ac = ac_in;
    cc = cc_in;
    if (ac >= h) ac = h - 1;
    if (cc >= h) cc = h - 1;
    hosts     = 2 * h * h * h;
    edge_base = hosts;
    agg_base  = edge_base + 2 * h * h;
    core_base = agg_base + 2 * h * h;

    if (src >= hosts || dst >= hosts) begin
      r      = make_hop(0, LVL_HOST);
      r.last = 1'b1;
      r.blk  = 1'b1;
      path_q.push_back(r);
      return;
    end

    se = src / h;
    de = dst / h;
    sp = se / h;
    dp = de / h;

    hops.push_back(make_hop(src, LVL_HOST));
    if (src != dst) begin
      hops.push_back(make_hop(edge_base + se, LVL_EDGE));
      if (se != de) begin
        hops.push_back(make_hop(agg_base + ac + h * sp, LVL_AGG));
        if (sp != dp) begin
          hops.push_back(make_hop(core_base + cc + h * ac, LVL_CORE));
          hops.push_back(make_hop(agg_base + ac + h * dp, LVL_AGG));
        end
        hops.push_back(make_hop(edge_base + de, LVL_EDGE));
      end
      hops.push_back(make_hop(dst, LVL_HOST));
    end
    hops[hops.size() - 1].last = 1'b1;
    foreach (hops[i]) path_q.push_back(hops[i]);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      path_q.delete();
      radix_reg = RADIX_W'(2);
    end else begin
      if (cfg_wen) radix_reg = cfg_wdata;
      // Results are retired before new requests are planned; a request never
      // produces a node in the cycle it is accepted.
      if (out_valid && out_ready) begin
        if (path_q.size() == 0) begin
          report_mismatch($sformatf("node %0d arrived with nothing expected", node_id));
        end else begin
          want = path_q.pop_front();
          if (node_id != want.id)
            report_mismatch($sformatf("node_id %0d, expected %0d", node_id, want.id));
          if (node_level != want.level)
            report_mismatch($sformatf("node_level %0d, expected %0d", node_level, want.level));
          if (last_hop != want.last)
            report_mismatch($sformatf("last_hop %0b, expected %0b (node %0d)",
                                      last_hop, want.last, want.id));
          if (blocked != want.blk)
            report_mismatch($sformatf("blocked %0b, expected %0b (node %0d)",
                                      blocked, want.blk, want.id));
        end
      end
      if (in_valid && in_ready) plan_route(source_host, dest_host, agg_choice, core_choice);
    end
    outstanding <= path_q.size();
  end

endmodule

>>> bench/tb.sv
// Top of the route generator bench: clock, reset, request stimulus, sink and verdict.
`timescale 1ns / 100ps

module tb;
  import frt_pkg::*;

  localparam int CYCLE_LIMIT = 150000;
  localparam int LONG_HOLD   = 150;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_wen;
  logic [RADIX_W-1:0]  cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  logic [HOST_W-1:0]   source_host;
  logic [HOST_W-1:0]   dest_host;
  logic [CHOICE_W-1:0] agg_choice;
  logic [CHOICE_W-1:0] core_choice;
  logic                out_valid;
  logic                out_ready;
  logic [NODE_W-1:0]   node_id;
  logic [1:0]          node_level;
  logic                last_hop;
  logic                blocked;

  int          errors;
  int          outstanding;
  int          cycles = 0;
  int unsigned eff_h  = 2;
  bit          calm   = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  fat_tree_route_generator uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .source_host (source_host),
    .dest_host   (dest_host),
    .agg_choice  (agg_choice),
    .core_choice (core_choice),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .node_id     (node_id),
    .node_level  (node_level),
    .last_hop    (last_hop),
    .blocked     (blocked)
  );

  frt_route_checker route_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .source_host (source_host),
    .dest_host   (dest_host),
    .agg_choice  (agg_choice),
    .core_choice (core_choice),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .node_id     (node_id),
    .node_level  (node_level),
    .last_hop    (last_hop),
    .blocked     (blocked),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Offers one request and returns at the edge where the transaction completes.
  task automatic send_request(input int unsigned src, input int unsigned dst,
                              input int unsigned ac, input int unsigned cc);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    source_host <= HOST_W'(src);
    dest_host   <= HOST_W'(dst);
    agg_choice  <= CHOICE_W'(ac);
    core_choice <= CHOICE_W'(cc);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Lets every path in flight drain, then writes the radix register.
  task automatic set_radix(input int unsigned value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= RADIX_W'(value);
    @(posedge clk);
    cfg_wen <= 1'b0;
    eff_h = (value == 0) ? 1 : (value > MAX_HALF_RADIX) ? MAX_HALF_RADIX : value;
  endtask

  // Mostly in-range host pairs spread over the path shapes, plus out-of-range and noise.
  task automatic random_requests(input int count);
    int unsigned h, hosts, kind, src, dst, ac, cc;
    h     = eff_h;
    hosts = 2 * h * h * h;
    repeat (count) begin
      kind = $urandom_range(0, 9);
      src  = $urandom_range(0, hosts - 1);
      dst  = $urandom_range(0, hosts - 1);
      case (kind)
        0: begin
          dst = src;
        end
        1, 2: begin
          dst = (src / h) * h + $urandom_range(0, h - 1);
        end
        3, 4: begin
          dst = (src / (h * h)) * (h * h) + $urandom_range(0, h * h - 1);
        end
        8: begin
          src = $urandom_range(0, 65535);
          dst = $urandom_range(0, 65535);
        end
        9: begin
          if (hosts <= 65535) begin
            if ($urandom_range(0, 1)) src = $urandom_range(hosts, 65535);
            else dst = $urandom_range(hosts, 65535);
          end else begin
            src = $urandom_range(0, 65535);
          end
        end
        default: begin
        end
      endcase
      ac = $urandom_range(0, 1) ? $urandom_range(0, h - 1) : $urandom_range(0, 31);
      cc = $urandom_range(0, 1) ? $urandom_range(0, h - 1) : $urandom_range(0, 31);
      send_request(src, dst, ac, cc);
    end
  endtask

  // Sink: random back-pressure per node, and one long hold-off early in the run
  // so the request queue fills and the input stalls.
  initial begin
    int unsigned stall;
    int          taken;
    taken = 0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (taken == 30) stall = LONG_HOLD;
      else stall = calm ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  initial begin
    rst         <= 1'b1;
    cfg_wen     <= 1'b0;
    cfg_wdata   <= '0;
    in_valid    <= 1'b0;
    source_host <= '0;
    dest_host   <= '0;
    agg_choice  <= '0;
    core_choice <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset radix of 2: sixteen hosts, four per pod.
    send_request(0, 0, 0, 0);
    send_request(15, 15, 31, 31);
    send_request(0, 1, 0, 0);
    send_request(2, 3, 1, 1);
    send_request(0, 3, 0, 0);
    send_request(4, 7, 1, 0);
    send_request(0, 15, 0, 0);
    send_request(15, 0, 1, 1);
    send_request(5, 10, 31, 31);
    send_request(8, 2, 2, 0);
    send_request(12, 1, 1, 31);
    send_request(16, 0, 0, 0);
    send_request(0, 16, 0, 0);
    send_request(65535, 65535, 31, 31);
    send_request(16'h8000, 3, 0, 0);
    send_request(3, 16'h7fff, 1, 1);
    random_requests(30);

    set_radix(1);
    random_requests(30);

    calm = 1'b1;
    set_radix(0);
    random_requests(30);

    calm = 1'b0;
    set_radix(32);
    // Largest tree: every 16-bit host is valid and the top core switch is reachable.
    send_request(65535, 0, 31, 31);
    send_request(0, 65535, 0, 0);
    send_request(65535, 65534, 31, 31);
    send_request(65535, 65535, 5, 5);
    random_requests(40);

    set_radix(63);
    random_requests(30);

    calm = 1'b1;
    set_radix(3);
    random_requests(30);

    calm = 1'b0;
    set_radix(7);
    random_requests(30);

    set_radix(17);
    random_requests(30);

    set_radix(2);
    random_requests(20);

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
